// File: sv/dnc_pkg.sv
// Shared types, constants and helper functions for the day-number-to-date converter.
`default_nettype none

package dnc_pkg;

    localparam int NUM_STAGES = 8;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    typedef struct packed {
        logic [23:0] day_number;
        logic [26:0] day_fraction_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [16:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [9:0]         millisecond;
    } out_item_t;

    // calendar_mode codes
    localparam logic MODE_GREGORIAN = 1'b0;
    localparam logic MODE_JULIAN    = 1'b1;

    // Date constants, Meeus terms scaled to integers
    localparam logic [26:0] ALPHA_BIAS    = 27'd128179;  // -7468865 + 52*146097
    localparam logic [24:0] GREG_B_OFFSET = 25'd1486;    // 1524 + 1 - 39
    localparam logic [24:0] JUL_B_OFFSET  = 25'd1524;
    localparam logic [30:0] YEAR_SCALE    = 31'd100;
    localparam logic [30:0] C_BIAS        = 31'd12210;
    localparam logic [26:0] DAYS_4YEARS   = 27'd1461;
    localparam logic [3:0]  E_MONTH_WRAP  = 4'd14;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic signed [16:0] YEAR_OFS_LATE  = 17'sd4716;
    localparam logic signed [16:0] YEAR_OFS_EARLY = 17'sd4715;

    // Exact reciprocals: q = (x * ceil(2^k/d)) >> k for x < 2^n, k = n + clog2(d)
    localparam int ALPHA_SHIFT = 45;
    localparam logic [27:0] ALPHA_RECIP =
        28'(((64'd1 << ALPHA_SHIFT) + 64'd146096) / 64'd146097);
    localparam int YEAR_SHIFT = 47;
    localparam logic [31:0] YEAR_RECIP =
        32'(((64'd1 << YEAR_SHIFT) + 64'd36524) / 64'd36525);
    localparam int SEC_SHIFT = 37;
    localparam logic [27:0] SEC_RECIP =
        28'(((64'd1 << SEC_SHIFT) + 64'd999) / 64'd1000);
    localparam int MIN_SHIFT = 23;
    localparam logic [17:0] MIN_RECIP =
        18'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);
    localparam int HOUR_SHIFT = 17;
    localparam logic [11:0] HOUR_RECIP =
        12'(((64'd1 << HOUR_SHIFT) + 64'd59) / 64'd60);

    // Time constants
    localparam logic [26:0] MS_DAY_MAX = 27'd86399999;
    localparam logic [26:0] MS_PER_SEC = 27'd1000;
    localparam logic [16:0] SEC_PER_MIN = 17'd60;
    localparam logic [10:0] MIN_PER_HOUR = 11'd60;
    localparam logic [9:0]  MS_ROUND_UP = 10'd999;
    localparam logic [5:0]  SEC_LAST  = 6'd59;
    localparam logic [5:0]  MIN_LAST  = 6'd59;
    localparam logic [4:0]  HOUR_LAST = 5'd23;

    // floor(10000*x/306001) for x in 123..488: count thresholds ceil(30.6001*k)
    function automatic logic [3:0] e_from_x(input logic [8:0] x);
        logic [3:0] e;
        e = '0;
        for (int k = 1; k <= 15; k++)
        begin
            if (x >= 9'((306001 * k + 9999) / 10000))
                e = 4'(k);
        end
        return e;
    endfunction

    // floor(30.6001*e)
    function automatic logic [8:0] month_base(input logic [3:0] e);
        logic [8:0] base;
        base = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (e == 4'(k))
                base = 9'((306001 * k) / 10000);
        end
        return base;
    endfunction

endpackage

`default_nettype wire

// File: sv/dnc_pipe_ctl.sv
// Valid bits and per-stage load enables for the conversion pipeline.
`default_nettype none

module dnc_pipe_ctl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output dnc_pkg::stage_en_t    stage_en
);

    logic [dnc_pkg::NUM_STAGES-1:0] valid_reg;
    logic [dnc_pkg::NUM_STAGES-1:0] valid_next;

    // A stage loads when it is empty or its contents move on; bubbles get squeezed out.
    always_comb
    begin
        stage_en[dnc_pkg::NUM_STAGES-1] = !valid_reg[dnc_pkg::NUM_STAGES-1] || !out_stall;
        for (int i = dnc_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
            valid_next[0] = in_valid;
        for (int i = 1; i < dnc_pkg::NUM_STAGES; i++)
        begin
            if (stage_en[i])
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall  = !stage_en[0];
    assign out_valid = valid_reg[dnc_pkg::NUM_STAGES-1];

endmodule

`default_nettype wire

// File: sv/dnc_date.sv
// Date datapath: day number to year, month and day (Meeus), eight register stages.
`default_nettype none

module dnc_date (
    input  wire logic                clk,
    input  wire dnc_pkg::stage_en_t  stage_en,
    input  wire logic                mode,
    input  wire logic [23:0]         day_number,
    output logic signed [16:0]       year,
    output logic [3:0]               month,
    output logic [4:0]               day_of_month
);

    // stage 0
    logic [26:0] p0_reg, p0_next;
    logic [23:0] z0_reg;
    // stage 1
    logic [54:0] alpha_prod;
    logic [9:0]  q1_reg, q1_next;
    logic [23:0] z1_reg;
    // stage 2
    logic [24:0] b2_reg, b2_next;
    // stage 3
    logic [30:0] n3_reg, n3_next;
    logic [24:0] b3_reg;
    // stage 4
    logic [62:0] year_prod;
    logic [15:0] c4_reg, c4_next;
    logic [24:0] b4_reg;
    // stage 5
    logic [26:0] d_full;
    logic [24:0] x_full;
    logic [8:0]  x5_reg, x5_next;
    logic [15:0] c5_reg;
    // stage 6
    logic [3:0]  e6_reg, e6_next;
    logic [8:0]  x6_reg;
    logic [15:0] c6_reg;
    // stage 7
    logic signed [16:0] year_reg, year_next;
    logic [3:0]         month_reg, month_next;
    logic [4:0]         day_reg, day_next;
    logic [8:0]         day_wide;

    assign p0_next = {1'b0, day_number, 2'b00} + dnc_pkg::ALPHA_BIAS;

    // alpha + 52 = floor(p / 146097)
    assign alpha_prod = 55'(p0_reg) * 55'(dnc_pkg::ALPHA_RECIP);
    assign q1_next    = alpha_prod[dnc_pkg::ALPHA_SHIFT +: 10];

    // alpha - floor(alpha/4) + 1 folds to q - floor(q/4) - 38
    always_comb
    begin
        if (mode == dnc_pkg::MODE_GREGORIAN)
            b2_next = 25'(z1_reg) + 25'(q1_reg) - 25'(q1_reg[9:2]) + dnc_pkg::GREG_B_OFFSET;
        else
            b2_next = 25'(z1_reg) + dnc_pkg::JUL_B_OFFSET;
    end

    assign n3_next = 31'(b2_reg) * dnc_pkg::YEAR_SCALE - dnc_pkg::C_BIAS;

    assign year_prod = 63'(n3_reg) * 63'(dnc_pkg::YEAR_RECIP);
    assign c4_next   = year_prod[dnc_pkg::YEAR_SHIFT +: 16];

    // b - floor(1461c/4) always lands in 123..488
    assign d_full  = 27'(c4_reg) * dnc_pkg::DAYS_4YEARS;
    assign x_full  = b4_reg - 25'(d_full[26:2]);
    assign x5_next = x_full[8:0];

    assign e6_next = dnc_pkg::e_from_x(x5_reg);

    always_comb
    begin
        day_wide = x6_reg - dnc_pkg::month_base(e6_reg);
        day_next = day_wide[4:0];
        if (e6_reg < dnc_pkg::E_MONTH_WRAP)
            month_next = e6_reg - 4'd1;
        else
            month_next = e6_reg - 4'd13;
        if (month_next > dnc_pkg::MONTH_FEB)
            year_next = $signed(17'(c6_reg)) - dnc_pkg::YEAR_OFS_LATE;
        else
            year_next = $signed(17'(c6_reg)) - dnc_pkg::YEAR_OFS_EARLY;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            p0_reg <= p0_next;
            z0_reg <= day_number;
        end
        if (stage_en[1])
        begin
            q1_reg <= q1_next;
            z1_reg <= z0_reg;
        end
        if (stage_en[2])
            b2_reg <= b2_next;
        if (stage_en[3])
        begin
            n3_reg <= n3_next;
            b3_reg <= b2_reg;
        end
        if (stage_en[4])
        begin
            c4_reg <= c4_next;
            b4_reg <= b3_reg;
        end
        if (stage_en[5])
        begin
            x5_reg <= x5_next;
            c5_reg <= c4_reg;
        end
        if (stage_en[6])
        begin
            e6_reg <= e6_next;
            x6_reg <= x5_reg;
            c6_reg <= c5_reg;
        end
        if (stage_en[7])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = day_reg;

endmodule

`default_nettype wire

// File: sv/dnc_time.sv
// Time-of-day datapath: milliseconds of day to h/m/s/ms with optional round-up.
`default_nettype none

module dnc_time (
    input  wire logic                clk,
    input  wire dnc_pkg::stage_en_t  stage_en,
    input  wire logic                mode,
    input  wire logic [26:0]         day_fraction_ms,
    output logic [4:0]               hour,
    output logic [5:0]               minute,
    output logic [5:0]               second,
    output logic [9:0]               millisecond
);

    // stage 0
    logic [26:0] t0_reg, t0_next;
    // stage 1
    logic [54:0] sec_prod;
    logic [16:0] s1_reg, s1_next;
    logic [26:0] t1_reg;
    // stage 2
    logic [26:0] ms_full;
    logic [34:0] min_prod;
    logic [9:0]  ms2_reg, ms2_next;
    logic [10:0] m2_reg, m2_next;
    logic [16:0] s2_reg;
    // stage 3
    logic [16:0] sec_full;
    logic [22:0] hour_prod;
    logic [5:0]  sec3_reg, sec3_next;
    logic [4:0]  h3_reg, h3_next;
    logic [10:0] m3_reg;
    logic [9:0]  ms3_reg;
    // stage 4
    logic [10:0] min_full;
    logic [5:0]  min4_reg, min4_next;
    logic [4:0]  h4_reg;
    logic [5:0]  sec4_reg;
    logic [9:0]  ms4_reg;
    // stage 5: rounding
    logic        round_up;
    logic [4:0]  h5_reg, h5_next;
    logic [5:0]  min5_reg, min5_next;
    logic [5:0]  sec5_reg, sec5_next;
    logic [9:0]  ms5_reg, ms5_next;
    // stages 6, 7: alignment with the date path
    logic [4:0]  h6_reg, h7_reg;
    logic [5:0]  min6_reg, min7_reg;
    logic [5:0]  sec6_reg, sec7_reg;
    logic [9:0]  ms6_reg, ms7_reg;

    assign t0_next = (day_fraction_ms > dnc_pkg::MS_DAY_MAX) ? dnc_pkg::MS_DAY_MAX
                                                              : day_fraction_ms;

    assign sec_prod = 55'(t0_reg) * 55'(dnc_pkg::SEC_RECIP);
    assign s1_next  = sec_prod[dnc_pkg::SEC_SHIFT +: 17];

    assign ms_full  = t1_reg - 27'(s1_reg) * dnc_pkg::MS_PER_SEC;
    assign ms2_next = ms_full[9:0];
    assign min_prod = 35'(s1_reg) * 35'(dnc_pkg::MIN_RECIP);
    assign m2_next  = min_prod[dnc_pkg::MIN_SHIFT +: 11];

    assign sec_full  = s2_reg - 17'(m2_reg) * dnc_pkg::SEC_PER_MIN;
    assign sec3_next = sec_full[5:0];
    assign hour_prod = 23'(m2_reg) * 23'(dnc_pkg::HOUR_RECIP);
    assign h3_next   = hour_prod[dnc_pkg::HOUR_SHIFT +: 5];

    assign min_full  = m3_reg - 11'(h3_reg) * dnc_pkg::MIN_PER_HOUR;
    assign min4_next = min_full[5:0];

    // Gregorian mode rounds .999 up; hour wraps without touching the date
    always_comb
    begin
        round_up  = (mode == dnc_pkg::MODE_GREGORIAN) && (ms4_reg == dnc_pkg::MS_ROUND_UP);
        h5_next   = h4_reg;
        min5_next = min4_reg;
        sec5_next = sec4_reg;
        ms5_next  = ms4_reg;
        if (round_up)
        begin
            ms5_next = '0;
            if (sec4_reg == dnc_pkg::SEC_LAST)
            begin
                sec5_next = '0;
                if (min4_reg == dnc_pkg::MIN_LAST)
                begin
                    min5_next = '0;
                    if (h4_reg == dnc_pkg::HOUR_LAST)
                        h5_next = '0;
                    else
                        h5_next = h4_reg + 5'd1;
                end
                else
                begin
                    min5_next = min4_reg + 6'd1;
                end
            end
            else
            begin
                sec5_next = sec4_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
            t0_reg <= t0_next;
        if (stage_en[1])
        begin
            s1_reg <= s1_next;
            t1_reg <= t0_reg;
        end
        if (stage_en[2])
        begin
            ms2_reg <= ms2_next;
            m2_reg  <= m2_next;
            s2_reg  <= s1_reg;
        end
        if (stage_en[3])
        begin
            sec3_reg <= sec3_next;
            h3_reg   <= h3_next;
            m3_reg   <= m2_reg;
            ms3_reg  <= ms2_reg;
        end
        if (stage_en[4])
        begin
            min4_reg <= min4_next;
            h4_reg   <= h3_reg;
            sec4_reg <= sec3_reg;
            ms4_reg  <= ms3_reg;
        end
        if (stage_en[5])
        begin
            h5_reg   <= h5_next;
            min5_reg <= min5_next;
            sec5_reg <= sec5_next;
            ms5_reg  <= ms5_next;
        end
        if (stage_en[6])
        begin
            h6_reg   <= h5_reg;
            min6_reg <= min5_reg;
            sec6_reg <= sec5_reg;
            ms6_reg  <= ms5_reg;
        end
        if (stage_en[7])
        begin
            h7_reg   <= h6_reg;
            min7_reg <= min6_reg;
            sec7_reg <= sec6_reg;
            ms7_reg  <= ms6_reg;
        end
    end

    assign hour        = h7_reg;
    assign minute      = min7_reg;
    assign second      = sec7_reg;
    assign millisecond = ms7_reg;

endmodule

`default_nettype wire

// File: sv/day_number_to_calendar_date_core.sv
// Julian day number to calendar date and time of day: top level.
//
// Input beat: in_data carries day_number (integer part of JD + 0.5) and
// day_fraction_ms (milliseconds into that day, values past the end of the
// day saturate). Output beat: out_data carries year, month, day_of_month,
// hour, minute, second and millisecond. Both channels transfer on a rising
// edge with valid high and stall low.
// cfg_we/cfg_wdata write calendar_mode (0 Gregorian with .999 round-up,
// 1 Julian calendar); write it only while no beat is in flight.
// Pipeline: eight register stages. Throughput: one beat per clock while
// out_stall stays low.
// Reset clears all stage valid bits and sets calendar_mode to Gregorian.
// When out_stall holds a result, earlier stages keep filling any empty slots;
// in_stall rises only once every stage holds a beat.
`default_nettype none

module day_number_to_calendar_date_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire dnc_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output dnc_pkg::out_item_t      out_data
);

    logic               calendar_mode_reg;
    dnc_pkg::stage_en_t stage_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            calendar_mode_reg <= dnc_pkg::MODE_GREGORIAN;
        else if (cfg_we)
            calendar_mode_reg <= cfg_wdata;
    end

    dnc_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stage_en  (stage_en)
    );

    dnc_date u_date (
        .clk          (clk),
        .stage_en     (stage_en),
        .mode         (calendar_mode_reg),
        .day_number   (in_data.day_number),
        .year         (out_data.year),
        .month        (out_data.month),
        .day_of_month (out_data.day_of_month)
    );

    dnc_time u_time (
        .clk             (clk),
        .stage_en        (stage_en),
        .mode            (calendar_mode_reg),
        .day_fraction_ms (in_data.day_fraction_ms),
        .hour            (out_data.hour),
        .minute          (out_data.minute),
        .second          (out_data.second),
        .millisecond     (out_data.millisecond)
    );

endmodule

`default_nettype wire
